// ----- hw/rtl/fsrc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsrc_pkg
// Shared types, constants and the CRC16-CCITT byte update for the framed
// serial receiver.
// ----------------------------------------------------------------------------
package fsrc_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] START_FIRST_RESET  = 8'hAA;
   localparam logic [7:0] START_SECOND_RESET = 8'h55;
   localparam logic [7:0] EXPECTED_TYPE_RESET = 8'h00;
   localparam logic [8:0] EXPECTED_LEN_RESET = 9'd0;
   localparam logic       ACK_ENABLE_RESET = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_TYPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_LEN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_ENABLE = 3'd4;

   localparam logic [2:0] HDR_SEQ    = 3'd0;
   localparam logic [2:0] HDR_TS0    = 3'd1;
   localparam logic [2:0] HDR_TS1    = 3'd2;
   localparam logic [2:0] HDR_TS2    = 3'd3;
   localparam logic [2:0] HDR_TS3    = 3'd4;
   localparam logic [2:0] HDR_TYPE   = 3'd5;
   localparam logic [2:0] HDR_LEN_LO = 3'd6;
   localparam logic [2:0] HDR_LEN_HI = 3'd7;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic [8:0] LEN_SATURATED = 9'd511;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC_ERR  = 2'd1,
      STATUS_BAD_TYPE = 2'd2,
      STATUS_BAD_LEN  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] start_first;
      logic [7:0] start_second;
      logic [7:0] expected_type;
      logic [8:0] expected_len;
      logic       ack_enable;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  seq;
      logic [7:0]  frame_type;
      logic [8:0]  body_len;
      logic [31:0] timestamp;
      status_type  status;
      logic        ack_request;
   } rsp_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [8:0] sat_len(input logic [15:0] len);
      logic [8:0] r;
      if (len > 16'(LEN_SATURATED)) begin
         r = LEN_SATURATED;
      end else begin
         r = len[8:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/framed_serial_receiver_crc16_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// framed_serial_receiver_crc16_top
// Framed serial receiver with CRC16-CCITT frame check.
//
// Received bytes enter on the req channel, one transaction per byte. Results
// leave on the rsp channel: a payload byte transaction for every payload byte,
// and one verdict transaction at the end of each frame (after the high CRC
// byte, or right after the header when the length is oversized).
// A byte accepted into the input register is parsed while it is held there,
// and its result is registered in the result register, which drives rsp. One
// byte is accepted in every cycle while rsp_stall is not holding back a valid
// result; the parser's byte-wide CRC update is combinational.
// When the receiver stalls, the result register holds its transaction and the
// parser stops; req_stall rises as soon as the input register holds a byte, so
// at most one more byte is taken while that register is empty. Configuration
// is written through the csr channel, which is always ready, and is expected
// only while the block is idle.
// Reset clears the channels, restores the register defaults and returns the
// parser to hunting for the first start byte.
// ----------------------------------------------------------------------------
module framed_serial_receiver_crc16_top #(
   parameter int MAX_BODY = 256
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_kind,
   output logic [7:0]                            rsp_payload_byte,
   output logic [7:0]                            rsp_payload_index,
   output logic [7:0]                            rsp_seq,
   output logic [7:0]                            rsp_frame_type,
   output logic [8:0]                            rsp_body_len,
   output logic [31:0]                           rsp_timestamp,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_ack_request,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fsrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [fsrc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import fsrc_pkg::*;

   cfg_type    cfg;
   rsp_type    res;
   rsp_type    rsp;
   logic       advance;
   logic       in_valid;
   logic [7:0] in_byte;

   fsrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   fsrc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   fsrc_parser #(
      .MAX_BODY (MAX_BODY)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (in_valid && advance),
      .rx_byte (in_byte),
      .cfg     (cfg),
      .res     (res)
   );

   fsrc_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .advance   (advance),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_valid = rsp.valid;
   assign rsp_kind = rsp.kind;
   assign rsp_payload_byte = rsp.payload_byte;
   assign rsp_payload_index = rsp.payload_index;
   assign rsp_seq = rsp.seq;
   assign rsp_frame_type = rsp.frame_type;
   assign rsp_body_len = rsp.body_len;
   assign rsp_timestamp = rsp.timestamp;
   assign rsp_status = rsp.status;
   assign rsp_ack_request = rsp.ack_request;

endmodule
`default_nettype wire

// ----- hw/rtl/fsrc_csr.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsrc_csr
// Configuration registers written through the csr write channel.
// ----------------------------------------------------------------------------
module fsrc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [fsrc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [fsrc_pkg::CSR_DATA_W-1:0]    csr_data,
   output fsrc_pkg::cfg_type                       cfg
);
   import fsrc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_FIRST:   cfg_in.start_first = csr_data[7:0];
            CSR_START_SECOND:  cfg_in.start_second = csr_data[7:0];
            CSR_EXPECTED_TYPE: cfg_in.expected_type = csr_data[7:0];
            CSR_EXPECTED_LEN:  cfg_in.expected_len = csr_data[8:0];
            CSR_ACK_ENABLE:    cfg_in.ack_enable = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_first   <= START_FIRST_RESET;
         cfg_ff.start_second  <= START_SECOND_RESET;
         cfg_ff.expected_type <= EXPECTED_TYPE_RESET;
         cfg_ff.expected_len  <= EXPECTED_LEN_RESET;
         cfg_ff.ack_enable    <= ACK_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/fsrc_in_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsrc_in_stage
// Input register for received bytes; stalls the sender while a held byte
// cannot move on to the parser.
// ----------------------------------------------------------------------------
module fsrc_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       advance,
   output logic            in_valid,
   output logic [7:0]      in_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       take;

   assign req_stall = valid_ff && !advance;
   assign take = req_valid && !req_stall;
   assign in_valid = valid_ff;
   assign in_byte = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      byte_in = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in = req_rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/fsrc_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsrc_parser
// Frame state machine: start byte hunt, header capture, payload pass-through,
// running CRC16-CCITT and the frame verdict.
// ----------------------------------------------------------------------------
module fsrc_parser #(
   parameter int MAX_BODY = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        rx_byte,
   input  wire fsrc_pkg::cfg_type cfg,
   output fsrc_pkg::rsp_type      res
);
   import fsrc_pkg::*;

   localparam int OFF_W = $clog2(MAX_BODY + 1);

   typedef enum logic [2:0] {
      ST_HUNT1,
      ST_HUNT2,
      ST_HEADER,
      ST_PAYLOAD,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

   state_type        state_ff, state_in;
   logic [2:0]       hdr_idx_ff, hdr_idx_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [7:0]       seq_ff, seq_in;
   logic [31:0]      timestamp_ff, timestamp_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      length_ff, length_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       crc_low_ff, crc_low_in;
   logic [15:0]      crc_next;
   logic [15:0]      len_new;

   always_comb begin
      state_in = state_ff;
      hdr_idx_in = hdr_idx_ff;
      off_in = off_ff;
      seq_in = seq_ff;
      timestamp_in = timestamp_ff;
      type_in = type_ff;
      length_in = length_ff;
      crc_in = crc_ff;
      crc_low_in = crc_low_ff;
      crc_next = crc_add(crc_ff, rx_byte);
      len_new = {rx_byte, length_ff[7:0]};
      res = '0;
      if (step) begin
         case (state_ff)
            ST_HUNT1: begin
               if (rx_byte == cfg.start_first) begin
                  state_in = ST_HUNT2;
               end
            end
            ST_HUNT2: begin
               if (rx_byte == cfg.start_second) begin
                  state_in = ST_HEADER;
                  crc_in = CRC_INIT;
                  hdr_idx_in = HDR_SEQ;
               end else begin
                  state_in = ST_HUNT1;
               end
            end
            ST_HEADER: begin
               crc_in = crc_next;
               hdr_idx_in = hdr_idx_ff + 3'd1;
               case (hdr_idx_ff)
                  HDR_SEQ:    seq_in = rx_byte;
                  HDR_TS0:    timestamp_in[7:0] = rx_byte;
                  HDR_TS1:    timestamp_in[15:8] = rx_byte;
                  HDR_TS2:    timestamp_in[23:16] = rx_byte;
                  HDR_TS3:    timestamp_in[31:24] = rx_byte;
                  HDR_TYPE:   type_in = rx_byte;
                  HDR_LEN_LO: length_in = {8'h00, rx_byte};
                  HDR_LEN_HI: begin
                     length_in = len_new;
                     off_in = '0;
                     if (len_new > 16'(MAX_BODY)) begin
                        res.valid = 1'b1;
                        res.kind = KIND_VERDICT;
                        res.frame_type = type_ff;
                        res.body_len = sat_len(len_new);
                        res.timestamp = timestamp_ff;
                        res.status = STATUS_BAD_LEN;
                        res.ack_request = cfg.ack_enable;
                        state_in = ST_HUNT1;
                        crc_in = CRC_INIT;
                     end else if (len_new == 16'd0) begin
                        state_in = ST_CRC_LO;
                     end else begin
                        state_in = ST_PAYLOAD;
                     end
                  end
                  default: ;
               endcase
            end
            ST_PAYLOAD: begin
               crc_in = crc_next;
               off_in = off_ff + 1'b1;
               res.valid = 1'b1;
               res.kind = KIND_PAYLOAD;
               res.payload_byte = rx_byte;
               res.payload_index = 8'(off_ff);
               if (16'(off_ff) == length_ff - 16'd1) begin
                  state_in = ST_CRC_LO;
               end
            end
            ST_CRC_LO: begin
               crc_low_in = rx_byte;
               state_in = ST_CRC_HI;
            end
            ST_CRC_HI: begin
               res.valid = 1'b1;
               res.kind = KIND_VERDICT;
               res.seq = seq_ff;
               res.frame_type = type_ff;
               res.body_len = sat_len(length_ff);
               res.timestamp = timestamp_ff;
               res.ack_request = cfg.ack_enable;
               if ({rx_byte, crc_low_ff} != crc_ff) begin
                  res.status = STATUS_CRC_ERR;
               end else if (type_ff != cfg.expected_type) begin
                  res.status = STATUS_BAD_TYPE;
               end else if (cfg.expected_len != 9'd0 &&
                            length_ff != 16'(cfg.expected_len)) begin
                  res.status = STATUS_BAD_LEN;
               end else begin
                  res.status = STATUS_OK;
               end
               state_in = ST_HUNT1;
               crc_in = CRC_INIT;
            end
            default: state_in = ST_HUNT1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT1;
         hdr_idx_ff <= HDR_SEQ;
         off_ff <= '0;
         seq_ff <= 8'h00;
         timestamp_ff <= 32'h0;
         type_ff <= 8'h00;
         length_ff <= 16'h0;
         crc_ff <= CRC_INIT;
         crc_low_ff <= 8'h00;
      end else begin
         state_ff <= state_in;
         hdr_idx_ff <= hdr_idx_in;
         off_ff <= off_in;
         seq_ff <= seq_in;
         timestamp_ff <= timestamp_in;
         type_ff <= type_in;
         length_ff <= length_in;
         crc_ff <= crc_in;
         crc_low_ff <= crc_low_in;
      end
   end

   a_payload_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> 16'(off_ff) < length_ff)
      else $error("payload offset ran past the header length");

   a_payload_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind == KIND_PAYLOAD |-> state_ff == ST_PAYLOAD)
      else $error("payload transaction produced outside the payload phase");

   a_crc_seeded: assert property (@(posedge clock) disable iff (reset)
      step && state_ff == ST_HUNT2 && rx_byte == cfg.start_second
      |=> crc_ff == CRC_INIT && state_ff == ST_HEADER)
      else $error("CRC not seeded at frame start");

   a_verdict_ends_frame: assert property (@(posedge clock) disable iff (reset)
      res.valid && res.kind == KIND_VERDICT |=> state_ff == ST_HUNT1)
      else $error("receiver did not return to hunting after a verdict");

endmodule
`default_nettype wire

// ----- hw/rtl/fsrc_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fsrc_out_stage
// Result register; holds a transaction while the receiver stalls and tells
// the parser when it may advance.
// ----------------------------------------------------------------------------
module fsrc_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire fsrc_pkg::rsp_type res,
   output logic                   advance,
   input  wire logic              rsp_stall,
   output fsrc_pkg::rsp_type      rsp
);
   import fsrc_pkg::*;

   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign advance = !rsp_ff.valid || !rsp_stall;
   assign rsp = rsp_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (advance) begin
         rsp_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.kind <= rsp_in.kind;
      rsp_ff.payload_byte <= rsp_in.payload_byte;
      rsp_ff.payload_index <= rsp_in.payload_index;
      rsp_ff.seq <= rsp_in.seq;
      rsp_ff.frame_type <= rsp_in.frame_type;
      rsp_ff.body_len <= rsp_in.body_len;
      rsp_ff.timestamp <= rsp_in.timestamp;
      rsp_ff.status <= rsp_in.status;
      rsp_ff.ack_request <= rsp_in.ack_request;
   end

endmodule
`default_nettype wire
